// ===== hdl/arpu_pkg.sv =====
package arpu_pkg;

  typedef enum logic [2:0] {
    FN_ADDKEY   = 3'd0,
    FN_SUB      = 3'd1,
    FN_INVSUB   = 3'd2,
    FN_SHIFT    = 3'd3,
    FN_INVSHIFT = 3'd4,
    FN_MIX      = 3'd5,
    FN_INVMIX   = 3'd6,
    FN_PASS     = 3'd7
  } func_t;

  typedef logic [7:0] byte_t;
  typedef byte_t [15:0] state_t;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam byte_t INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic byte_t xt(input byte_t v);
    xt = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

// ===== hdl/arpu_mix_col.sv =====
module arpu_mix_col
  import arpu_pkg::*;
(
  input  logic        inv,
  input  logic [31:0] col_in,
  output logic [31:0] col_out
);

  byte_t a [4];
  byte_t m2 [4];
  byte_t m4 [4];
  byte_t m8 [4];
  byte_t m3 [4];
  byte_t m9 [4];
  byte_t mb [4];
  byte_t md [4];
  byte_t me [4];
  byte_t o [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      a[k]  = col_in[31-8*k -: 8];
      m2[k] = xt(a[k]);
      m4[k] = xt(m2[k]);
      m8[k] = xt(m4[k]);
      m3[k] = m2[k] ^ a[k];
      m9[k] = m8[k] ^ a[k];
      mb[k] = m8[k] ^ m2[k] ^ a[k];
      md[k] = m8[k] ^ m4[k] ^ a[k];
      me[k] = m8[k] ^ m4[k] ^ m2[k];
    end
    for (int r = 0; r < 4; r++) begin
      if (inv) begin
        o[r] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
      end else begin
        o[r] = m2[r] ^ m3[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
      end
      col_out[31-8*r -: 8] = o[r];
    end
  end

endmodule

// ===== hdl/aes_round_primitive_unit_top.sv =====
// a result beat is registered, shown the cycle after its input beat is taken
// throughput: one beat per cycle, set by a single input-to-result register stage
// with stall on the output the result register holds and a new beat is taken
// only when the result register is empty or being drained
// reset: rst_n synchronous active low clears the result valid flag
module aes_round_primitive_unit_top
  import arpu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [63:0] in_state_hi,
  input  logic [63:0] in_state_lo,
  input  logic [63:0] in_key_hi,
  input  logic [63:0] in_key_lo,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_hi,
  output logic [63:0] out_result_lo
);

  logic          valid_r;
  logic [127:0]  res_r;
  logic [127:0]  res_nxt;
  logic [127:0]  st;
  logic [127:0]  mixed;
  state_t        s;
  state_t        t;
  logic          take;

  assign st       = {in_state_hi, in_state_lo};
  assign in_stall = valid_r & out_stall;
  assign take     = in_valid & ~in_stall;

  for (genvar c = 0; c < 4; c++) begin : g_mix
    arpu_mix_col u_mix (
      .inv     (in_func == FN_INVMIX),
      .col_in  (st[127-32*c -: 32]),
      .col_out (mixed[127-32*c -: 32])
    );
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = st[127-8*i -: 8];
    end
    t = s;
    res_nxt = st;
    unique case (func_t'(in_func))
      FN_ADDKEY: res_nxt = st ^ {in_key_hi, in_key_lo};
      FN_SUB: begin
        for (int i = 0; i < 16; i++) t[i] = SBOX[s[i]];
      end
      FN_INVSUB: begin
        for (int i = 0; i < 16; i++) t[i] = INV_SBOX[s[i]];
      end
      FN_SHIFT: begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++) t[4*c+r] = s[4*((c+r)%4)+r];
      end
      FN_INVSHIFT: begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++) t[4*c+r] = s[4*((c-r+4)%4)+r];
      end
      FN_MIX, FN_INVMIX: res_nxt = mixed;
      default: res_nxt = st;
    endcase
    if (in_func == FN_SUB || in_func == FN_INVSUB || in_func == FN_SHIFT ||
        in_func == FN_INVSHIFT) begin
      for (int i = 0; i < 16; i++) res_nxt[127-8*i -: 8] = t[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_result_hi = res_r[127:64];
  assign out_result_lo = res_r[63:0];

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench
  import arpu_pkg::*;
;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_func = '0;
  logic [63:0] in_state_hi = '0;
  logic [63:0] in_state_lo = '0;
  logic [63:0] in_key_hi = '0;
  logic [63:0] in_key_lo = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_result_hi;
  logic [63:0] out_result_lo;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } round_out_t;

  round_out_t  pending_states[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_cycles = 0;
  int unsigned rx_wait = 0;
  bit          rx_idle_en = 1'b1;
  bit          tx_idle_en = 1'b1;
  localparam int unsigned CYCLE_LIMIT = 200000;

  aes_round_primitive_unit_top i_dut (.*);

  always #1 clk = ~clk;

  function automatic byte_t gmul(input byte_t a, input byte_t b);
    byte_t acc;
    byte_t x;
    acc = '0;
    x = a;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) acc ^= x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  function automatic byte_t sub_byte(input byte_t v);
    byte_t inv;
    byte_t p;
    inv = 8'h01;
    p = v;
    for (int e = 0; e < 8; e++) begin
      if (e != 0) inv = gmul(inv, p);
      p = gmul(p, p);
    end
    if (v == '0) inv = '0;
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
      ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  function automatic round_out_t predict_round(input logic [2:0] fn, input logic [63:0] shi,
      input logic [63:0] slo, input logic [63:0] khi, input logic [63:0] klo);
    byte_t s[16];
    byte_t t[16];
    byte_t m[4];
    byte_t col[4];
    round_out_t r;
    for (int i = 0; i < 8; i++) begin
      s[i] = shi[63-8*i -: 8];
      s[8+i] = slo[63-8*i -: 8];
    end
    t = s;
    if (fn == FN_MIX) m = '{8'd2, 8'd3, 8'd1, 8'd1};
    else m = '{8'd14, 8'd11, 8'd13, 8'd9};
    case (func_t'(fn))
      FN_ADDKEY: begin
        for (int i = 0; i < 8; i++) begin
          t[i] = s[i] ^ khi[63-8*i -: 8];
          t[8+i] = s[8+i] ^ klo[63-8*i -: 8];
        end
      end
      FN_SUB: for (int i = 0; i < 16; i++) t[i] = sub_byte(s[i]);
      FN_INVSUB: begin
        for (int i = 0; i < 16; i++)
          for (int c = 0; c < 256; c++)
            if (sub_byte(byte_t'(c)) == s[i]) t[i] = byte_t'(c);
      end
      FN_SHIFT, FN_INVSHIFT: begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++)
            t[4*c+r] = s[4*((fn == FN_SHIFT) ? ((c + r) & 3) : ((c - r + 4) & 3)) + r];
      end
      FN_MIX, FN_INVMIX: begin
        for (int c = 0; c < 4; c++) begin
          for (int k = 0; k < 4; k++) col[k] = s[4*c+k];
          for (int r = 0; r < 4; r++) begin
            t[4*c+r] = '0;
            for (int k = 0; k < 4; k++) t[4*c+r] ^= gmul(m[(k - r + 4) & 3], col[k]);
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < 8; i++) begin
      r.hi[63-8*i -: 8] = t[i];
      r.lo[63-8*i -: 8] = t[8+i];
    end
    return r;
  endfunction

  task automatic send_beat(input logic [2:0] fn, input logic [63:0] shi,
      input logic [63:0] slo, input logic [63:0] khi, input logic [63:0] klo);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 7) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= fn;
    in_state_hi <= shi;
    in_state_lo <= slo;
    in_key_hi <= khi;
    in_key_lo <= klo;
    pending_states.push_back(predict_round(fn, shi, slo, khi, klo));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_states.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [63:0] ones;
    ones = '1;
    for (int f = 0; f < 8; f++) begin
      send_beat(3'(f), '0, '0, '0, '0);
      send_beat(3'(f), ones, ones, ones, ones);
      send_beat(3'(f), 64'h0011223344556677, 64'h8899aabbccddeeff, rand64(), rand64());
    end
    send_beat(FN_ADDKEY, 64'h0123456789abcdef, 64'hfedcba9876543210, ones, '0);
    go_idle();
  endtask

  task automatic test_random();
    for (int n = 0; n < 1500; n++)
      send_beat(3'($urandom_range(0, 7)), rand64(), rand64(), rand64(), rand64());
    go_idle();
  endtask

  task automatic test_back_to_back();
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    for (int n = 0; n < 100; n++)
      send_beat(3'($urandom_range(0, 7)), rand64(), rand64(), rand64(), rand64());
    go_idle();
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    drain_results();
    hold_cycles = 40;
    for (int n = 0; n < 30; n++)
      send_beat(3'($urandom_range(0, 7)), rand64(), rand64(), rand64(), rand64());
    drain_results();
  endtask

  // receiver stall control, wait drawn per beat
  always @(posedge clk) begin
    int unsigned w;
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      out_stall <= 1'b1;
    end else if (rx_idle_en && out_valid && !out_stall) begin
      w = $urandom_range(0, 7);
      out_stall <= (w != 0);
      rx_wait <= (w != 0) ? w - 1 : 0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    round_out_t exp_st;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_states.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected beat %h %h", out_result_hi, out_result_lo);
      end else begin
        exp_st = pending_states.pop_front();
        if (out_result_hi !== exp_st.hi || out_result_lo !== exp_st.lo) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp %h %h got %h %h", exp_st.hi, exp_st.lo,
              out_result_hi, out_result_lo);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_back_to_back();
    test_backpressure();
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_states.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
